FILE: sv/fnd_pkg.sv
// Shared types and constants for the feedback nibble delta filter.
// Used by fnd_ctrl, fnd_dp, feedback_nibble_delta_filter and the testbench; depends on nothing.

package fnd_pkg;

    localparam int MODE_W    = 3;
    localparam int SILENCE_W = 26;
    localparam int WDOG_W    = 16;
    localparam int LIMIT_W   = 26;

    localparam logic [MODE_W-1:0] MODE_REPORT = 3'd0;
    localparam logic [MODE_W-1:0] MODE_TICK   = 3'd1;
    localparam logic [MODE_W-1:0] MODE_PWR_ON = 3'd2;
    localparam logic [MODE_W-1:0] MODE_PWR_OFF = 3'd3;
    localparam logic [MODE_W-1:0] MODE_CLEAR  = 3'd4;

    localparam logic KIND_CHANGE  = 1'b0;
    localparam logic KIND_RESTART = 1'b1;

    localparam logic REG_FILTER   = 1'b0;
    localparam logic REG_WATCHDOG = 1'b1;

    localparam logic              FILTER_RESET   = 1'b1;
    localparam logic [WDOG_W-1:0] WATCHDOG_RESET = 16'd15;

    localparam logic [SILENCE_W-1:0] SILENCE_MAX   = 26'h3FF_FFFF;
    localparam logic [LIMIT_W-1:0]   MS_PER_SECOND = 26'd1000;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic accept;
        logic commit;
    } t_cmd;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic has_result;
    } t_sts;

endpackage

FILE: sv/fnd_ctrl.sv
// Controller of the feedback nibble delta filter: item sequencing and output valid.
// Depends on fnd_pkg.

module fnd_ctrl (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_s_tvalid,
    output logic          o_s_tready,
    output logic          o_m_tvalid,
    input  logic          i_m_tready,
    input  fnd_pkg::t_sts i_sts,
    output fnd_pkg::t_cmd o_cmd
);
    import fnd_pkg::*;

    localparam logic ST_IDLE = 1'b0;
    localparam logic ST_EXEC = 1'b1;

    logic r_state;
    logic n_state;
    logic r_out_valid;
    logic n_out_valid;
    logic commit;

    // An item may finish unless it has a result and the output register is still held and not being taken.
    assign commit = (r_state == ST_EXEC) &&
                    (!i_sts.has_result || !r_out_valid || i_m_tready);

    assign o_s_tready   = (r_state == ST_IDLE);
    assign o_m_tvalid   = r_out_valid;
    assign o_cmd.accept = i_s_tvalid && (r_state == ST_IDLE);
    assign o_cmd.commit = commit;

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: begin
                if (i_s_tvalid) begin
                    n_state = ST_EXEC;
                end
            end
            ST_EXEC: begin
                if (commit) begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_comb begin
        n_out_valid = r_out_valid;
        if (commit && i_sts.has_result) begin
            n_out_valid = 1'b1;
        end else if (i_m_tready) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

endmodule

FILE: sv/fnd_dp.sv
// Datapath of the feedback nibble delta filter: nibble cache, seen flags,
// silence watchdog and result register. Depends on fnd_pkg.

module fnd_dp #(
    parameter int MODULE_COUNT = 128
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  fnd_pkg::t_cmd                 i_cmd,
    output fnd_pkg::t_sts                 o_sts,
    input  logic [fnd_pkg::MODE_W-1:0]    i_mode,
    input  logic [7:0]                    i_bus_address,
    input  logic [7:0]                    i_bus_data,
    input  logic                          i_filter_on,
    input  logic [fnd_pkg::WDOG_W-1:0]    i_watchdog_seconds,
    output logic                          o_kind,
    output logic [6:0]                    o_proto_address,
    output logic [6:0]                    o_itnz_byte
);
    import fnd_pkg::*;

    localparam int SLOTS = 2 * MODULE_COUNT;
    localparam int SW    = (SLOTS > 1) ? $clog2(SLOTS) : 1;

    logic [3:0]           mem [SLOTS];
    logic [SLOTS-1:0]     r_written;
    logic [SLOTS-1:0]     r_unseen;
    logic [MODE_W-1:0]    r_mode;
    logic [7:0]           r_addr;
    logic [7:0]           r_data;
    logic [SW-1:0]        r_slot;
    logic [3:0]           r_rd_val;
    logic                 r_powered;
    logic [SILENCE_W-1:0] r_silence;
    logic [SILENCE_W-1:0] n_silence;
    logic [LIMIT_W-1:0]   r_limit;
    logic                 r_kind;
    logic [6:0]           r_proto_address;
    logic [6:0]           r_itnz_byte;

    logic [7:0]           in_addr_m1;
    logic [7:0]           in_slot_wide;
    logic [SW-1:0]        in_slot;
    logic [7:0]           addr_m1;
    logic                 in_range;
    logic [3:0]           cur_val;
    logic                 changed;
    logic [SILENCE_W-1:0] silence_inc;
    logic                 wd_fire;
    logic                 has_result;
    logic                 cache_we;

    assign in_addr_m1   = i_bus_address - 8'd1;
    assign in_slot_wide = {in_addr_m1[6:0], i_bus_data[4]};
    assign in_slot      = in_slot_wide[SW-1:0];

    assign addr_m1  = r_addr - 8'd1;
    assign in_range = (r_addr != 8'd0) && (r_addr <= 8'(MODULE_COUNT));
    // An entry never written since reset or clear-all reads as zero.
    assign cur_val  = r_written[r_slot] ? r_rd_val : 4'd0;
    assign changed  = r_unseen[r_slot] || (cur_val != r_data[3:0]);

    assign silence_inc = (r_silence == SILENCE_MAX) ? r_silence : r_silence + 1'b1;
    assign wd_fire     = r_powered && (i_watchdog_seconds != '0) && (silence_inc >= r_limit);

    always_comb begin
        unique case (r_mode)
            MODE_REPORT: has_result = in_range && (changed || !i_filter_on);
            MODE_TICK:   has_result = wd_fire;
            default:     has_result = 1'b0;
        endcase
    end

    assign o_sts.has_result = has_result;
    assign cache_we = i_cmd.commit && (r_mode == MODE_REPORT) && in_range;

    always_comb begin
        unique case (r_mode)
            MODE_REPORT: n_silence = '0;
            MODE_TICK:   n_silence = wd_fire ? '0 : silence_inc;
            MODE_PWR_ON: n_silence = '0;
            default:     n_silence = r_silence;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.accept) begin
            r_rd_val <= mem[in_slot];
        end
        if (cache_we) begin
            mem[r_slot] <= r_data[3:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.accept) begin
            r_mode <= i_mode;
            r_addr <= i_bus_address;
            r_data <= i_bus_data;
            r_slot <= in_slot;
        end
        r_limit <= LIMIT_W'(i_watchdog_seconds) * MS_PER_SECOND;
        if (i_cmd.commit && has_result) begin
            r_kind <= (r_mode == MODE_TICK) ? KIND_RESTART : KIND_CHANGE;
            r_proto_address <= (r_mode == MODE_TICK) ? 7'd0 : addr_m1[6:0];
            r_itnz_byte     <= (r_mode == MODE_TICK) ? 7'd0 : r_data[6:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_written <= '0;
            r_unseen  <= '0;
            r_powered <= 1'b0;
            r_silence <= '0;
        end else if (i_cmd.commit) begin
            r_silence <= n_silence;
            unique case (r_mode)
                MODE_REPORT: begin
                    if (in_range) begin
                        r_written[r_slot] <= 1'b1;
                        r_unseen[r_slot]  <= 1'b0;
                    end
                end
                MODE_PWR_ON: begin
                    r_powered <= 1'b1;
                    r_unseen  <= '1;
                end
                MODE_PWR_OFF: begin
                    r_powered <= 1'b0;
                end
                MODE_CLEAR: begin
                    r_written <= '0;
                    r_unseen  <= '0;
                end
                default: begin
                end
            endcase
        end
    end

    assign o_kind          = r_kind;
    assign o_proto_address = r_proto_address;
    assign o_itnz_byte     = r_itnz_byte;

endmodule

FILE: sv/feedback_nibble_delta_filter.sv
// An item is taken in the idle state, which reads the nibble cache (a registered memory
// read); the exec state compares, updates the cache and the watchdog and loads the result
// register. A new item is taken only after the previous one finishes, back in the idle
// state, so the block never takes an item while one is in progress; an item with a result
// waits in the exec state only while the previous result is still held on the output.
// There is no clearing pass: per-entry written and unseen flags make reset, power-on and
// clear-all take effect at once. Top level; depends on fnd_pkg, fnd_ctrl and fnd_dp.

module feedback_nibble_delta_filter #(
    parameter int MODULE_COUNT = 128
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [15:0] s_tdata,   // [7:0] bus_address, [15:8] bus_data
    input  logic [2:0]  s_tuser,   // [2:0] mode
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [15:0] m_tdata,   // [6:0] proto_address, [13:7] itnz_byte, [15:14] zero
    output logic        m_tuser,   // [0] kind
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);
    import fnd_pkg::*;

    t_cmd              cmd;
    t_sts              sts;
    logic              r_filter_on;
    logic [WDOG_W-1:0] r_watchdog_seconds;
    logic              cfg_we;
    logic [6:0]        proto_address;
    logic [6:0]        itnz_byte;

    assign pready = 1'b1;
    assign cfg_we = psel && penable && pwrite;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_filter_on        <= FILTER_RESET;
            r_watchdog_seconds <= WATCHDOG_RESET;
        end else if (cfg_we) begin
            if (paddr[2] == REG_FILTER) begin
                r_filter_on <= pwdata[0];
            end else begin
                r_watchdog_seconds <= pwdata[WDOG_W-1:0];
            end
        end
    end

    assign prdata = (paddr[2] == REG_WATCHDOG) ? {16'd0, r_watchdog_seconds}
                                              : {31'd0, r_filter_on};

    fnd_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (s_tvalid),
        .o_s_tready (s_tready),
        .o_m_tvalid (m_tvalid),
        .i_m_tready (m_tready),
        .i_sts      (sts),
        .o_cmd      (cmd)
    );

    fnd_dp #(
        .MODULE_COUNT (MODULE_COUNT)
    ) u_dp (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_cmd              (cmd),
        .o_sts              (sts),
        .i_mode             (s_tuser),
        .i_bus_address      (s_tdata[7:0]),
        .i_bus_data         (s_tdata[15:8]),
        .i_filter_on        (r_filter_on),
        .i_watchdog_seconds (r_watchdog_seconds),
        .o_kind             (m_tuser),
        .o_proto_address    (proto_address),
        .o_itnz_byte        (itnz_byte)
    );

    assign m_tdata = {2'b00, itnz_byte, proto_address};

`ifndef ASSERT_OFF
    // One item at a time: in the cycle after an item is taken the input is closed.
    a_one_item: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s_tvalid && s_tready) |=> !s_tready)
        else $error("input accepted while an item was still in progress");

    // A restart result carries an all-zero payload.
    a_restart_payload: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_tvalid && (m_tuser == KIND_RESTART)) |-> (m_tdata == 16'd0))
        else $error("restart result with nonzero payload");

    // A new result is never loaded over one that is held and not being taken.
    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (cmd.commit && sts.has_result && m_tvalid) |-> m_tready)
        else $error("result register overwritten while held");
`endif

endmodule

FILE: sim/feedback_nibble_delta_filter_checker.sv
`timescale 1ns / 100ps
// Checker for the feedback nibble delta filter: it watches the input, output and APB
// channels, keeps its own copy of the cache and watchdog and compares every result.
// Depends on fnd_pkg.

module feedback_nibble_delta_filter_checker #(
    parameter int MODULE_COUNT = 128
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_tvalid,
    input  logic        s_tready,
    input  logic [15:0] s_tdata,   // [7:0] bus_address, [15:8] bus_data
    input  logic [2:0]  s_tuser,   // [2:0] mode
    input  logic        m_tvalid,
    input  logic        m_tready,
    input  logic [15:0] m_tdata,   // [6:0] proto_address, [13:7] itnz_byte, [15:14] zero
    input  logic        m_tuser,   // [0] kind
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    input  logic [31:0] prdata,
    input  logic        pready,
    output int          o_errors,
    output int          o_outstanding
);

    import fnd_pkg::*;

    typedef struct packed {
        logic       kind;
        logic [6:0] proto_address;
        logic [6:0] itnz_byte;
    } t_fb_result;

    // Bit 4 of each entry marks a nibble not seen since power on.
    logic [4:0]           last_nibble [0:2*MODULE_COUNT-1];
    logic [1:0]           last_type   [0:MODULE_COUNT-1];
    logic                 bus_powered;
    logic [SILENCE_W-1:0] quiet_ms;
    logic                 filter_on;
    logic [WDOG_W-1:0]    timeout_s;

    t_fb_result due_outputs[$];
    int         err_count = 0;
    int         shown = 0;

    task automatic note_mismatch(input string what, input int unsigned want,
                                 input int unsigned got);
        if (want != got) begin
            err_count++;
            if (shown < 40) begin
                shown++;
                $display("%0t ns: %s mismatch, expected 0x%0h, actual 0x%0h",
                         $time, what, want, got);
            end
        end
    endtask

    task automatic predict_filter_output(input logic [MODE_W-1:0] mode,
                                         input logic [7:0] addr, input logic [7:0] data);
        int                 slot;
        logic               changed;
        logic [7:0]         zero_based;
        logic [LIMIT_W-1:0] limit_ms;
        t_fb_result         res;
        case (mode)
            MODE_REPORT: begin
                // Any report, even to a missing module, counts as bus traffic.
                quiet_ms = '0;
                if (addr != 8'd0 && addr <= MODULE_COUNT) begin
                    zero_based = addr - 8'd1;
                    slot = int'(zero_based) * 2 + int'(data[4]);
                    last_type[zero_based] = data[6:5];
                    changed = last_nibble[slot][4] || (last_nibble[slot][3:0] != data[3:0]);
                    last_nibble[slot] = {1'b0, data[3:0]};
                    if (changed || !filter_on) begin
                        res.kind          = KIND_CHANGE;
                        res.proto_address = zero_based[6:0];
                        // Type, nibble select and value already sit in bits 6 to 0.
                        res.itnz_byte     = data[6:0];
                        due_outputs.push_back(res);
                    end
                end
            end
            MODE_TICK: begin
                if (quiet_ms != SILENCE_MAX)
                    quiet_ms = quiet_ms + 1'b1;
                limit_ms = timeout_s * MS_PER_SECOND;
                if (bus_powered && timeout_s != '0 && quiet_ms >= limit_ms) begin
                    quiet_ms = '0;
                    res = '0;
                    res.kind = KIND_RESTART;
                    due_outputs.push_back(res);
                end
            end
            MODE_PWR_ON: begin
                bus_powered = 1'b1;
                quiet_ms = '0;
                for (int i = 0; i < 2 * MODULE_COUNT; i++)
                    last_nibble[i][4] = 1'b1;
            end
            MODE_PWR_OFF: begin
                bus_powered = 1'b0;
            end
            MODE_CLEAR: begin
                for (int i = 0; i < 2 * MODULE_COUNT; i++)
                    last_nibble[i] = '0;
                for (int i = 0; i < MODULE_COUNT; i++)
                    last_type[i] = '0;
            end
            default: begin
            end
        endcase
    endtask

    always @(posedge i_clk) begin
        t_fb_result want;
        if (!i_rst_n) begin
            for (int i = 0; i < 2 * MODULE_COUNT; i++)
                last_nibble[i] = '0;
            for (int i = 0; i < MODULE_COUNT; i++)
                last_type[i] = '0;
            bus_powered = 1'b0;
            quiet_ms    = '0;
            filter_on   = FILTER_RESET;
            timeout_s   = WATCHDOG_RESET;
            due_outputs.delete();
        end else begin
            if (psel && penable && pready) begin
                if (pwrite) begin
                    if (paddr[2] == REG_FILTER)
                        filter_on = pwdata[0];
                    else
                        timeout_s = pwdata[WDOG_W-1:0];
                end else if (paddr[2] == REG_FILTER) begin
                    note_mismatch("filter register read", {31'b0, filter_on}, prdata);
                end else begin
                    note_mismatch("timeout register read", {16'b0, timeout_s}, prdata);
                end
            end
            if (s_tvalid && s_tready)
                predict_filter_output(s_tuser, s_tdata[7:0], s_tdata[15:8]);
            if (m_tvalid && m_tready) begin
                if (due_outputs.size() == 0) begin
                    err_count++;
                    if (shown < 40) begin
                        shown++;
                        $display("%0t ns: result with nothing expected, actual kind %0d tdata 0x%0h",
                                 $time, m_tuser, m_tdata);
                    end
                end else begin
                    want = due_outputs.pop_front();
                    note_mismatch("kind", want.kind, m_tuser);
                    note_mismatch("proto_address", want.proto_address, m_tdata[6:0]);
                    note_mismatch("itnz_byte", want.itnz_byte, m_tdata[13:7]);
                    note_mismatch("tdata padding", 0, m_tdata[15:14]);
                end
            end
        end
        o_errors      <= err_count;
        o_outstanding <= due_outputs.size();
    end

endmodule

FILE: sim/feedback_nibble_delta_filter_tb.sv
`timescale 1ns / 100ps
// Top of the feedback nibble delta filter testbench: clock, reset, stimulus and verdict.
// Depends on fnd_pkg, feedback_nibble_delta_filter and feedback_nibble_delta_filter_checker.

module feedback_nibble_delta_filter_tb;

    import fnd_pkg::*;

    localparam int MODULE_COUNT = 128;
    localparam int STALL_LIMIT  = 4000;
    localparam int LONG_HOLD    = 300;

    localparam logic [MODE_W-1:0] MODE_SPARE_FIRST = 3'd5;
    localparam logic [MODE_W-1:0] MODE_SPARE_LAST  = 3'd7;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        s_tvalid;
    logic        s_tready;
    logic [15:0] s_tdata;   // [7:0] bus_address, [15:8] bus_data
    logic [2:0]  s_tuser;   // [2:0] mode
    logic        m_tvalid;
    logic        m_tready;
    logic [15:0] m_tdata;   // [6:0] proto_address, [13:7] itnz_byte, [15:14] zero
    logic        m_tuser;   // [0] kind
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [2:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;

    int   errors;
    int   outstanding;
    int   idle_cycles = 0;
    int   items_sent = 0;
    int   results_seen = 0;
    int   restarts_seen = 0;
    logic tx_burst = 1'b0;
    logic rx_free = 1'b0;
    logic long_hold_req = 1'b0;

    always #1 i_clk = ~i_clk;

    feedback_nibble_delta_filter #(
        .MODULE_COUNT(MODULE_COUNT)
    ) DUT (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .prdata(prdata), .pready(pready)
    );

    feedback_nibble_delta_filter_checker #(
        .MODULE_COUNT(MODULE_COUNT)
    ) filter_check (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .prdata(prdata), .pready(pready),
        .o_errors(errors), .o_outstanding(outstanding)
    );

    // Progress watchdog and result statistics.
    always @(posedge i_clk) begin
        if (!i_rst_n || (s_tvalid && s_tready) || (m_tvalid && m_tready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (m_tvalid && m_tready) begin
            results_seen <= results_seen + 1;
            if (m_tuser == KIND_RESTART)
                restarts_seen <= restarts_seen + 1;
        end
        if (idle_cycles >= STALL_LIMIT) begin
            $display("%0t ns: no item moved for %0d cycles", $time, STALL_LIMIT);
            $display("CHECK FAILED");
            $finish;
        end
    end

    // Receiver: random back-pressure, free-running stretches and one long hold on request.
    initial begin : receiver
        int   left;
        int   pick;
        logic level;
        left  = 0;
        level = 1'b0;
        m_tready <= 1'b0;
        wait (i_rst_n);
        forever begin
            if (long_hold_req) begin
                long_hold_req = 1'b0;
                level = 1'b0;
                left  = LONG_HOLD;
            end else if (left <= 0) begin
                pick = $urandom_range(0, 99);
                if (rx_free) begin
                    level = 1'b1;
                    left  = 1;
                end else if (pick < 50) begin
                    level = 1'b1;
                    left  = $urandom_range(1, 20);
                end else if (pick < 55) begin
                    level = 1'b1;
                    left  = 60;
                end else if (pick < 85) begin
                    level = 1'b0;
                    left  = $urandom_range(1, 3);
                end else if (pick < 97) begin
                    level = 1'b0;
                    left  = $urandom_range(4, 12);
                end else begin
                    level = 1'b0;
                    left  = $urandom_range(30, 80);
                end
            end
            m_tready <= level;
            left--;
            @(posedge i_clk);
        end
    end

    task automatic drive(input logic [MODE_W-1:0] mode, input logic [7:0] addr,
                         input logic [7:0] data);
        int gap;
        int pick;
        s_tvalid <= 1'b1;
        s_tdata  <= {data, addr};
        s_tuser  <= mode;
        @(posedge i_clk);
        while (!s_tready)
            @(posedge i_clk);
        items_sent++;
        gap  = 0;
        pick = $urandom_range(0, 99);
        if (!tx_burst) begin
            if (pick >= 97)
                gap = $urandom_range(20, 60);
            else if (pick >= 90)
                gap = $urandom_range(4, 10);
            else if (pick >= 60)
                gap = $urandom_range(1, 3);
        end
        if (gap != 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
    endtask

    // Stop offering items and wait until every result is back and the pipeline is empty.
    task automatic settle;
        s_tvalid <= 1'b0;
        @(posedge i_clk);
        while (outstanding != 0)
            @(posedge i_clk);
        repeat (8) @(posedge i_clk);
    endtask

    task automatic apb_access(input logic wr, input logic idx, input logic [31:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= wr;
        paddr   <= {idx, 2'b00};
        pwdata  <= value;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (!pready)
            @(posedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        @(posedge i_clk);
    endtask

    // Upper bits of each write word are random; the block must ignore them.
    task automatic program_regs(input logic filter, input logic [WDOG_W-1:0] secs);
        logic [31:0] word;
        word = $urandom;
        word[0] = filter;
        apb_access(1'b1, REG_FILTER, word);
        apb_access(1'b0, REG_FILTER, '0);
        word = $urandom;
        word[WDOG_W-1:0] = secs;
        apb_access(1'b1, REG_WATCHDOG, word);
        apb_access(1'b0, REG_WATCHDOG, '0);
    endtask

    task automatic random_run(input int count, input int tick_pct);
        logic [MODE_W-1:0] mode;
        logic [7:0]        addr;
        logic [7:0]        data;
        int                pick;
        for (int n = 0; n < count; n++) begin
            if (n % 40 == 0)
                tx_burst = ($urandom_range(0, 4) == 0);
            pick = $urandom_range(0, 99);
            if (pick < tick_pct) begin
                mode = MODE_TICK;
            end else begin
                pick = $urandom_range(0, 99);
                if (pick < 86)
                    mode = MODE_REPORT;
                else if (pick < 90)
                    mode = MODE_PWR_ON;
                else if (pick < 93)
                    mode = MODE_PWR_OFF;
                else if (pick < 95)
                    mode = MODE_CLEAR;
                else
                    mode = MODE_W'($urandom_range(MODE_SPARE_FIRST, MODE_SPARE_LAST));
            end
            // A few hot modules and a narrow value range make repeats, and so suppression, common.
            pick = $urandom_range(0, 99);
            if (pick < 60)
                addr = 8'($urandom_range(1, 8));
            else if (pick < 85)
                addr = 8'($urandom_range(1, MODULE_COUNT));
            else if (pick < 90)
                addr = 8'(MODULE_COUNT);
            else if (pick < 93)
                addr = 8'd1;
            else if (pick < 96)
                addr = 8'd0;
            else
                addr = 8'($urandom_range(MODULE_COUNT + 1, 255));
            data = 8'($urandom_range(0, 255));
            if ($urandom_range(0, 1) == 1)
                data[3:0] = 4'($urandom_range(0, 1));
            drive(mode, addr, data);
        end
        tx_burst = 1'b0;
    endtask

    initial begin
        s_tvalid <= 1'b0;
        s_tdata  <= '0;
        s_tuser  <= MODE_REPORT;
        psel     <= 1'b0;
        penable  <= 1'b0;
        pwrite   <= 1'b0;
        paddr    <= '0;
        pwdata   <= '0;
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed items under the reset settings: filter on, timeout of 15 seconds.
        drive(MODE_REPORT, 8'd1, 8'h00);
        drive(MODE_REPORT, 8'd1, 8'h05);
        drive(MODE_REPORT, 8'd1, 8'h85);
        drive(MODE_REPORT, 8'(MODULE_COUNT), 8'h7F);
        drive(MODE_REPORT, 8'd0, 8'h3F);
        drive(MODE_REPORT, 8'(MODULE_COUNT + 1), 8'h12);
        drive(MODE_REPORT, 8'd255, 8'hFF);
        drive(MODE_PWR_ON, 8'd0, 8'h00);
        drive(MODE_REPORT, 8'd1, 8'h05);
        drive(MODE_REPORT, 8'd1, 8'h05);
        drive(MODE_REPORT, 8'(MODULE_COUNT), 8'h7F);
        drive(MODE_TICK, 8'hFF, 8'hFF);
        drive(MODE_TICK, 8'h00, 8'h00);
        drive(MODE_PWR_OFF, 8'hAA, 8'h55);
        drive(MODE_REPORT, 8'd64, 8'h41);
        drive(MODE_CLEAR, 8'h00, 8'h00);
        drive(MODE_REPORT, 8'd1, 8'h00);
        drive(MODE_REPORT, 8'(MODULE_COUNT), 8'h10);
        drive(MODE_REPORT, 8'd64, 8'hE1);
        drive(MODE_SPARE_FIRST, 8'd1, 8'h0F);
        drive(MODE_SPARE_FIRST + 3'd1, 8'd2, 8'h1F);
        drive(MODE_SPARE_LAST, 8'd3, 8'hFF);

        // Filter off, watchdog off: every valid report must come out.
        settle();
        program_regs(1'b0, '0);
        random_run(70, 8);
        // Hold the output for a long stretch while reports keep coming, so the block backs up.
        long_hold_req = 1'b1;
        tx_burst = 1'b1;
        repeat (40) drive(MODE_REPORT, 8'($urandom_range(1, MODULE_COUNT)),
                          8'($urandom_range(0, 255)));
        tx_burst = 1'b0;
        random_run(70, 8);

        // Filter on, longest timeout; the sender pauses half way until everything is back.
        settle();
        program_regs(1'b1, 16'hFFFF);
        random_run(60, 10);
        settle();
        random_run(60, 10);

        // Shortest timeout: a restart after exactly 1000 quiet ticks while powered.
        settle();
        program_regs(1'b1, 16'd1);
        tx_burst = 1'b1;
        rx_free  = 1'b1;
        drive(MODE_PWR_ON, 8'($urandom), 8'($urandom));
        repeat ($urandom_range(1000, 1010)) drive(MODE_TICK, 8'($urandom), 8'($urandom));
        drive(MODE_PWR_OFF, 8'($urandom), 8'($urandom));
        repeat (4) drive(MODE_TICK, 8'($urandom), 8'($urandom));
        drive(MODE_REPORT, 8'($urandom), 8'($urandom));
        tx_burst = 1'b0;
        rx_free  = 1'b0;

        settle();
        program_regs(1'b0, WDOG_W'($urandom_range(2, 9)));
        random_run(60, 15);

        settle();
        program_regs(1'b1, WDOG_W'($urandom_range(0, 65535)));
        random_run(55, 10);

        settle();
        repeat (10) @(posedge i_clk);
        $display("Summary: %0d items sent, %0d results checked, %0d of them watchdog restarts.",
                 items_sent, results_seen, restarts_seen);
        $display("Covered filter on and off, timeouts from 0 to 65535, power cycling, clear-all,");
        $display("out-of-range addresses, unused modes and output back-pressure.");
        if (errors == 0 && outstanding == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule
